// ===== sv/n_queens_backtrack_solver_assert.svh =====
// ----------------------------------------------------------------------------
// n_queens_backtrack_solver_assert.svh
// Assertion macros shared by the checker of the N-queens solver.
// ----------------------------------------------------------------------------
`ifndef N_QUEENS_BACKTRACK_SOLVER_ASSERT_SVH
`define N_QUEENS_BACKTRACK_SOLVER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define NQB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nqb: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define NQB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nqb: next-cycle check failed");

`endif

// ===== sv/nqb_pkg.sv =====
// ----------------------------------------------------------------------------
// nqb_pkg
// Shared constants of the N-queens backtracking solver.
// ----------------------------------------------------------------------------
package nqb_pkg;

    // Default largest board the search storage is sized for
    localparam int MAX_BOARD_DEF = 16;

    // Results per item never exceed this, so boards saturate to it, or to MAX_BOARD if smaller
    localparam int RESULT_LIMIT = 16;

    // Width of a row or column number on the result port and in the stack
    localparam int ROW_W = 4;

endpackage

// ===== sv/nqb_square_unit.sv =====
// ----------------------------------------------------------------------------
// nqb_square_unit
// Shared square unit: tests a square against the row and diagonal masks and
// gives the one-hot bits that place or lift a queen on it.
// ----------------------------------------------------------------------------
module nqb_square_unit #(
    parameter int MAX_BOARD = nqb_pkg::MAX_BOARD_DEF
) (
    input  logic [nqb_pkg::ROW_W-1:0] row,
    input  logic [nqb_pkg::ROW_W-1:0] col,
    input  logic [MAX_BOARD-1:0]      rows_taken,
    input  logic [2*MAX_BOARD-2:0]    fall_taken,
    input  logic [2*MAX_BOARD-2:0]    rise_taken,
    output logic                      free,
    output logic [MAX_BOARD-1:0]      row_bit,
    output logic [2*MAX_BOARD-2:0]    fall_bit,
    output logic [2*MAX_BOARD-2:0]    rise_bit
);

    localparam int DIAG_W     = 2 * MAX_BOARD - 1;
    localparam int DIAG_IDX_W = $clog2(DIAG_W);
    localparam int ROW_IDX_W  = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;

    logic [DIAG_IDX_W-1:0] fall_idx;
    logic [DIAG_IDX_W-1:0] rise_idx;

    // Map the square onto its two diagonals
    assign fall_idx = DIAG_IDX_W'(row) + DIAG_IDX_W'(MAX_BOARD - 1) - DIAG_IDX_W'(col);
    assign rise_idx = DIAG_IDX_W'(row) + DIAG_IDX_W'(col);

    // Decode one-hot mask bits
    assign row_bit  = MAX_BOARD'(1) << ROW_IDX_W'(row);
    assign fall_bit = DIAG_W'(1) << fall_idx;
    assign rise_bit = DIAG_W'(1) << rise_idx;

    // Square is free when none of its lines holds a queen
    assign free = ((rows_taken & row_bit) == '0) &&
                  ((fall_taken & fall_bit) == '0) &&
                  ((rise_taken & rise_bit) == '0);

endmodule

// ===== sv/n_queens_backtrack_solver.sv =====
// ----------------------------------------------------------------------------
// n_queens_backtrack_solver
// Depth-first backtracking search for the first placement of N queens.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with board_size. A size above the
// smaller of MAX_BOARD and 16 is saturated to that limit. The block takes one
// item, then holds in_stall high until the whole search and all of its
// results have been handed to the output register.
// Output channel: out_valid / out_stall with column_index, queen_row, found
// and last. A solution gives one item per column, in column order, with last
// on the final column; size 0 or a board with no placement gives a single
// item with found low and last high.
// Search steps: each candidate square tried is one check in the shared
// square unit; a step back reads the stack, then lifts the queen; each
// result is first read from the row stack memory port, then loaded into
// the output register.
// Reset clears the sequencer, masks and output valid; the row stack is not
// cleared since the search writes each entry before reading it. While the
// receiver stalls, the held result stays put and the sequencer waits.
// ----------------------------------------------------------------------------
module n_queens_backtrack_solver #(
    parameter int MAX_BOARD = nqb_pkg::MAX_BOARD_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [4:0]                board_size,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [nqb_pkg::ROW_W-1:0] column_index,
    output logic [nqb_pkg::ROW_W-1:0] queen_row,
    output logic                      found,
    output logic                      last
);

    localparam int ROW_W  = nqb_pkg::ROW_W;
    localparam int LIMIT  = (MAX_BOARD < nqb_pkg::RESULT_LIMIT) ?
                            MAX_BOARD : nqb_pkg::RESULT_LIMIT;
    localparam int CNT_W  = $clog2(LIMIT + 1);
    localparam int IDX_W  = $clog2(MAX_BOARD);
    localparam int DIAG_W = 2 * MAX_BOARD - 1;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_CHECK   = 6'b000010,
        S_POP     = 6'b000100,
        S_EMIT_RD = 6'b001000,
        S_EMIT    = 6'b010000,
        S_FAIL    = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [CNT_W-1:0]      col_reg, col_next;
    logic [CNT_W-1:0]      cand_reg, cand_next;
    logic [MAX_BOARD-1:0]  rows_taken_reg, rows_taken_next;
    logic [DIAG_W-1:0]     fall_taken_reg, fall_taken_next;
    logic [DIAG_W-1:0]     rise_taken_reg, rise_taken_next;

    logic [ROW_W-1:0]      stack_mem [MAX_BOARD];
    logic [ROW_W-1:0]      rd_data_reg;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;

    logic                  out_valid_reg;
    logic [ROW_W-1:0]      out_col_reg, out_col_next;
    logic [ROW_W-1:0]      out_row_reg, out_row_next;
    logic                  out_found_reg, out_found_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_load;
    logic                  out_free;

    logic [ROW_W-1:0]      unit_row;
    logic                  unit_free;
    logic [MAX_BOARD-1:0]  unit_row_bit;
    logic [DIAG_W-1:0]     unit_fall_bit;
    logic [DIAG_W-1:0]     unit_rise_bit;
    logic [CNT_W-1:0]      size_sat;

    // Saturate the requested size to the supported limit
    assign size_sat = (board_size > 5'(LIMIT)) ? CNT_W'(LIMIT) : CNT_W'(board_size);

    // Feed the shared unit: stacked row when stepping back, else the candidate
    assign unit_row = (state_reg == S_POP) ? rd_data_reg : ROW_W'(cand_reg);

    nqb_square_unit #(
        .MAX_BOARD (MAX_BOARD)
    ) u_square (
        .row        (unit_row),
        .col        (ROW_W'(col_reg)),
        .rows_taken (rows_taken_reg),
        .fall_taken (fall_taken_reg),
        .rise_taken (rise_taken_reg),
        .free       (unit_free),
        .row_bit    (unit_row_bit),
        .fall_bit   (unit_fall_bit),
        .rise_bit   (unit_rise_bit)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    // Sequence the search and the result stream
    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        col_next        = col_reg;
        cand_next       = cand_reg;
        rows_taken_next = rows_taken_reg;
        fall_taken_next = fall_taken_reg;
        rise_taken_next = rise_taken_reg;
        rd_en           = 1'b0;
        rd_addr         = IDX_W'(col_reg - CNT_W'(1));
        wr_en           = 1'b0;
        out_load        = 1'b0;
        out_col_next    = '0;
        out_row_next    = '0;
        out_found_next  = 1'b0;
        out_last_next   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n_next          = size_sat;
                    col_next        = '0;
                    cand_next       = '0;
                    rows_taken_next = '0;
                    fall_taken_next = '0;
                    rise_taken_next = '0;
                    state_next      = (size_sat == '0) ? S_FAIL : S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (col_reg == n_reg)
                begin
                    cand_next  = '0;
                    state_next = S_EMIT_RD;
                end
                else if (cand_reg == n_reg)
                begin
                    if (col_reg == '0)
                    begin
                        state_next = S_FAIL;
                    end
                    else
                    begin
                        // Step back: fetch previous column's row
                        rd_en      = 1'b1;
                        col_next   = col_reg - CNT_W'(1);
                        state_next = S_POP;
                    end
                end
                else if (unit_free)
                begin
                    // Place the queen and advance a column
                    wr_en           = 1'b1;
                    rows_taken_next = rows_taken_reg ^ unit_row_bit;
                    fall_taken_next = fall_taken_reg ^ unit_fall_bit;
                    rise_taken_next = rise_taken_reg ^ unit_rise_bit;
                    col_next        = col_reg + CNT_W'(1);
                    cand_next       = '0;
                end
                else
                begin
                    cand_next = cand_reg + CNT_W'(1);
                end
            end
            S_POP:
            begin
                // Lift the queen and try the row below it
                rows_taken_next = rows_taken_reg ^ unit_row_bit;
                fall_taken_next = fall_taken_reg ^ unit_fall_bit;
                rise_taken_next = rise_taken_reg ^ unit_rise_bit;
                cand_next       = CNT_W'(rd_data_reg) + CNT_W'(1);
                state_next      = S_CHECK;
            end
            S_EMIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(cand_reg);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                out_col_next   = ROW_W'(cand_reg);
                out_row_next   = rd_data_reg;
                out_found_next = 1'b1;
                out_last_next  = (cand_reg + CNT_W'(1)) == n_reg;
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (out_last_next)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cand_next  = cand_reg + CNT_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_FAIL:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold sequencer and occupancy masks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            n_reg          <= '0;
            col_reg        <= '0;
            cand_reg       <= '0;
            rows_taken_reg <= '0;
            fall_taken_reg <= '0;
            rise_taken_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            n_reg          <= n_next;
            col_reg        <= col_next;
            cand_reg       <= cand_next;
            rows_taken_reg <= rows_taken_next;
            fall_taken_reg <= fall_taken_next;
            rise_taken_reg <= rise_taken_next;
        end
    end

    // Row stack: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[IDX_W'(col_reg)] <= ROW_W'(cand_reg);
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    // Output valid: set on load, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_found_reg <= out_found_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign column_index = out_col_reg;
    assign queen_row    = out_row_reg;
    assign found        = out_found_reg;
    assign last         = out_last_reg;

endmodule

// ===== sv/nqb_checker.sv =====
// ----------------------------------------------------------------------------
// nqb_checker
// Port-level checks of the N-queens solver, bound to the top level.
// ----------------------------------------------------------------------------
`include "n_queens_backtrack_solver_assert.svh"

module nqb_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [nqb_pkg::ROW_W-1:0] column_index,
    input logic [nqb_pkg::ROW_W-1:0] queen_row,
    input logic                      found,
    input logic                      last
);

    // A no-solution item is a lone, zeroed final item
    `NQB_ASSERT_NOW(a_fail_shape, out_valid && !found, last && column_index == '0 && queen_row == '0)

    // A taken item keeps the block busy for at least the next cycle
    `NQB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // Mid-solution items come while the search still holds the input
    `NQB_ASSERT_NOW(a_busy_mid_stream, out_valid && found && !last, in_stall)

    // A stalled item stays and holds its fields
    `NQB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(column_index) && $stable(queen_row) && $stable(found) && $stable(last))

endmodule

bind n_queens_backtrack_solver nqb_checker u_nqb_checker (.*);
